FILE: rtl/core/rrci_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin class interleaver package
// Sizes and command codes shared by the front and back parts of the
// interleaver, and the status codes and sequencer states of the back part.
// ----------------------------------------------------------------------------
package rrci_pkg;

	// Store geometry.
	localparam int NUM_CLASSES = 256;
	localparam int MAX_ITEMS   = 4096;
	localparam int TAG_BITS    = 32;

	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SLOT_W = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int TAG_W  = TAG_BITS;

	// Port field widths.
	localparam int IN_TAG_W  = 32;
	localparam int IN_CLS_W  = 8;
	localparam int OUT_TAG_W = 32;
	localparam int OUT_CLS_W = 8;
	localparam int STAT_W    = 2;
	localparam int DATA_W    = 40;

	// Command kinds after classification in the front part.
	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_REJECT
	} op_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_PUSHED  = 2'd0,
		STAT_POPPED  = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_DROPPED = 2'd3
	} status_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_PUSH,
		S_POP_HEAD,
		S_POP_DATA
	} state_t;

	// One classified command held in the queue between front and back.
	typedef struct packed {
		op_t              op;
		logic [TAG_W-1:0] tag;
		logic [CLS_W-1:0] cls;
	} cmd_t;

	// Queue output toward the back part.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_t;

endpackage

FILE: rtl/core/round_robin_class_interleaver_core.sv
// ----------------------------------------------------------------------------
// Round-robin class interleaver core
// Per-class job queues in a shared linked store, served in round-robin order.
// ----------------------------------------------------------------------------
// Each input transaction is a push (tuser 0) of a job tag into its class queue
// or a pop (tuser 1) of the next job in round-robin class order; every input
// transaction yields exactly one output transaction with a status. Items are
// handled one at a time by the back-end sequencer. Its states follow the
// registered memory reads: a pop reads the class head and tail, then the
// slot's tag and link, and a push reads the class tail and the free-slot
// stack; a dropped push or a pop on an empty store needs no read. A
// two-entry queue in front lets input transactions arrive while the back end
// works or waits on a stalled output. No clearing pass is needed after reset.
module round_robin_class_interleaver_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rrci_pkg::DATA_W-1:0]       s_tdata,  // job_tag[31:0], class_index[39:32]
	input  logic [0:0]                        s_tuser,  // func[0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rrci_pkg::DATA_W-1:0]       m_tdata,  // out_tag[31:0], out_class[39:32]
	output logic [rrci_pkg::STAT_W-1:0]       m_tuser   // status[1:0]
);

	rrci_pkg::cmdq_t q_link;
	logic            q_pop;

	// Front end: accept and classify.
	rrci_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_out    (q_link),
		.q_pop    (q_pop)
	);

	// Back end: queue operations and results.
	rrci_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_in     (q_link),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: rtl/core/rrci_front.sv
// ----------------------------------------------------------------------------
// Round-robin class interleaver front end
// Accepts input transactions, classifies them into push, pop or reject, and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rrci_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rrci_pkg::DATA_W-1:0]       s_tdata,  // job_tag[31:0], class_index[39:32]
	input  logic [0:0]                        s_tuser,  // func[0]
	output rrci_pkg::cmdq_t                   q_out,
	input  logic                              q_pop
);

	rrci_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	rrci_pkg::cmd_t new_cmd;
	logic [rrci_pkg::IN_CLS_W-1:0] in_cls;
	logic           push;
	logic           pop;

	// Classify the incoming transaction.
	always_comb begin
		in_cls      = s_tdata[rrci_pkg::IN_TAG_W +: rrci_pkg::IN_CLS_W];
		new_cmd.tag = rrci_pkg::TAG_W'(s_tdata[rrci_pkg::IN_TAG_W-1:0]);
		new_cmd.cls = rrci_pkg::CLS_W'(in_cls);
		if (s_tuser[0]) begin
			new_cmd.op = rrci_pkg::OP_POP;
		end else if (int'(in_cls) < rrci_pkg::NUM_CLASSES) begin
			new_cmd.op = rrci_pkg::OP_PUSH;
		end else begin
			new_cmd.op = rrci_pkg::OP_REJECT;
		end
	end

	assign s_tready    = (cnt_q != 2'd2);
	assign push        = s_tvalid && s_tready;
	assign pop         = q_pop && (cnt_q != 2'd0);
	assign q_out.valid = (cnt_q != 2'd0);
	assign q_out.cmd   = entry_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/core/rrci_back.sv
// ----------------------------------------------------------------------------
// Round-robin class interleaver back end
// Carries out pushes and pops on the linked class queues and drives the
// registered result stream.
// ----------------------------------------------------------------------------
module rrci_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rrci_pkg::cmdq_t                   q_in,
	output logic                              q_pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rrci_pkg::DATA_W-1:0]       m_tdata,  // out_tag[31:0], out_class[39:32]
	output logic [rrci_pkg::STAT_W-1:0]       m_tuser   // status[1:0]
);

	localparam int SW = rrci_pkg::SLOT_W;
	localparam int CW = rrci_pkg::CLS_W;
	localparam int NW = rrci_pkg::CNT_W;
	localparam int TW = rrci_pkg::TAG_W;

	// Memories.
	logic [TW-1:0] tag_mem  [rrci_pkg::MAX_ITEMS];
	logic [SW-1:0] link_mem [rrci_pkg::MAX_ITEMS];
	logic [SW-1:0] stk_mem  [rrci_pkg::MAX_ITEMS];
	logic [SW-1:0] head_mem [rrci_pkg::NUM_CLASSES];
	logic [SW-1:0] tail_mem [rrci_pkg::NUM_CLASSES];

	logic          tag_we, tag_re, link_we, link_re, stk_we, stk_re;
	logic          head_we, head_re, tail_we, tail_re;
	logic [SW-1:0] tag_wa, tag_ra, link_wa, link_ra, stk_wa, stk_ra;
	logic [CW-1:0] head_wa, head_ra, tail_wa, tail_ra;
	logic [TW-1:0] tag_wd, tag_rd;
	logic [SW-1:0] link_wd, link_rd, stk_wd, stk_rd, head_wd, head_rd, tail_wd, tail_rd;

	// Control state.
	rrci_pkg::state_t         state_q, state_d;
	rrci_pkg::cmd_t           cmd_q, cmd_d;
	logic [SW-1:0]            slot_q, slot_d;
	logic                     last_q, last_d;
	logic [rrci_pkg::NUM_CLASSES-1:0] mask_q, mask_d;
	logic [CW-1:0]            rr_q, rr_d;
	logic [NW-1:0]            free_q, free_d;
	logic [NW-1:0]            stk_cnt_q, stk_cnt_d;
	logic [NW-1:0]            fresh_q, fresh_d;

	// Result register.
	logic                              out_valid_q;
	logic [rrci_pkg::OUT_TAG_W-1:0]    out_tag_q;
	logic [rrci_pkg::OUT_CLS_W-1:0]    out_cls_q;
	logic [rrci_pkg::STAT_W-1:0]       out_stat_q;
	logic                              emit;
	logic [rrci_pkg::OUT_TAG_W-1:0]    emit_tag;
	logic [rrci_pkg::OUT_CLS_W-1:0]    emit_cls;
	rrci_pkg::status_t                 emit_stat;
	logic                              out_free;

	// Rotating search results.
	logic          hit_hi, hit_any;
	logic [CW-1:0] c_hi, c_any, c_found;
	logic [SW-1:0] new_slot;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cls_q, out_tag_q};
	assign m_tuser  = out_stat_q;

	// First nonempty class at or after the pointer, else the first overall.
	always_comb begin
		hit_hi  = 1'b0;
		hit_any = 1'b0;
		c_hi    = '0;
		c_any   = '0;
		for (int i = rrci_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				hit_any = 1'b1;
				c_any   = CW'(i);
				if (i >= int'(rr_q)) begin
					hit_hi = 1'b1;
					c_hi   = CW'(i);
				end
			end
		end
		c_found = hit_hi ? c_hi : c_any;
	end

	// Slot handed to a push: a recycled one if any, else a never-used one.
	assign new_slot = (stk_cnt_q != '0) ? stk_rd : fresh_q[SW-1:0];

	// Next state, memory control and result generation.
	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		slot_d    = slot_q;
		last_d    = last_q;
		mask_d    = mask_q;
		rr_d      = rr_q;
		free_d    = free_q;
		stk_cnt_d = stk_cnt_q;
		fresh_d   = fresh_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_tag  = '0;
		emit_cls  = '0;
		emit_stat = rrci_pkg::STAT_PUSHED;
		tag_we = 1'b0; tag_re = 1'b0; tag_wa = '0; tag_ra = '0; tag_wd = '0;
		link_we = 1'b0; link_re = 1'b0; link_wa = '0; link_ra = '0; link_wd = '0;
		stk_we = 1'b0; stk_re = 1'b0; stk_wa = '0; stk_ra = '0; stk_wd = '0;
		head_we = 1'b0; head_re = 1'b0; head_wa = '0; head_ra = '0; head_wd = '0;
		tail_we = 1'b0; tail_re = 1'b0; tail_wa = '0; tail_ra = '0; tail_wd = '0;
		case (state_q)
			rrci_pkg::S_IDLE: begin
				if (q_in.valid && out_free) begin
					q_pop = 1'b1;
					cmd_d = q_in.cmd;
					case (q_in.cmd.op)
						rrci_pkg::OP_PUSH: begin
							if (free_q == '0) begin
								emit      = 1'b1;
								emit_stat = rrci_pkg::STAT_DROPPED;
							end else begin
								stk_re  = 1'b1;
								stk_ra  = SW'(stk_cnt_q - 1'b1);
								tail_re = 1'b1;
								tail_ra = q_in.cmd.cls;
								state_d = rrci_pkg::S_PUSH;
							end
						end
						rrci_pkg::OP_POP: begin
							if (!hit_any) begin
								emit      = 1'b1;
								emit_stat = rrci_pkg::STAT_EMPTY;
							end else begin
								cmd_d.cls = c_found;
								head_re   = 1'b1;
								head_ra   = c_found;
								tail_re   = 1'b1;
								tail_ra   = c_found;
								state_d   = rrci_pkg::S_POP_HEAD;
							end
						end
						default: begin
							emit      = 1'b1;
							emit_stat = rrci_pkg::STAT_DROPPED;
						end
					endcase
				end
			end
			rrci_pkg::S_PUSH: begin
				if (out_free) begin
					tag_we = 1'b1;
					tag_wa = new_slot;
					tag_wd = cmd_q.tag;
					if (mask_q[cmd_q.cls]) begin
						link_we = 1'b1;
						link_wa = tail_rd;
						link_wd = new_slot;
					end else begin
						head_we = 1'b1;
						head_wa = cmd_q.cls;
						head_wd = new_slot;
					end
					tail_we = 1'b1;
					tail_wa = cmd_q.cls;
					tail_wd = new_slot;
					mask_d[cmd_q.cls] = 1'b1;
					if (stk_cnt_q != '0) begin
						stk_cnt_d = stk_cnt_q - 1'b1;
					end else begin
						fresh_d = fresh_q + 1'b1;
					end
					free_d    = free_q - 1'b1;
					emit      = 1'b1;
					emit_stat = rrci_pkg::STAT_PUSHED;
					state_d   = rrci_pkg::S_IDLE;
				end
			end
			rrci_pkg::S_POP_HEAD: begin
				tag_re  = 1'b1;
				tag_ra  = head_rd;
				link_re = 1'b1;
				link_ra = head_rd;
				slot_d  = head_rd;
				last_d  = (head_rd == tail_rd);
				state_d = rrci_pkg::S_POP_DATA;
			end
			rrci_pkg::S_POP_DATA: begin
				if (out_free) begin
					if (last_q) begin
						mask_d[cmd_q.cls] = 1'b0;
					end else begin
						head_we = 1'b1;
						head_wa = cmd_q.cls;
						head_wd = link_rd;
					end
					stk_we    = 1'b1;
					stk_wa    = stk_cnt_q[SW-1:0];
					stk_wd    = slot_q;
					stk_cnt_d = stk_cnt_q + 1'b1;
					free_d    = free_q + 1'b1;
					if (free_d == NW'(rrci_pkg::MAX_ITEMS)) begin
						rr_d = '0;
					end else if (int'(cmd_q.cls) == rrci_pkg::NUM_CLASSES - 1) begin
						rr_d = '0;
					end else begin
						rr_d = cmd_q.cls + 1'b1;
					end
					emit      = 1'b1;
					emit_tag  = rrci_pkg::OUT_TAG_W'(tag_rd);
					emit_cls  = rrci_pkg::OUT_CLS_W'(cmd_q.cls);
					emit_stat = rrci_pkg::STAT_POPPED;
					state_d   = rrci_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rrci_pkg::S_IDLE;
			end
		endcase
	end

	// Slot data and link memories.
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (tag_re) begin
			tag_rd <= tag_mem[tag_ra];
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (link_re) begin
			link_rd <= link_mem[link_ra];
		end
	end

	// Free-slot stack of recycled slots.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd <= stk_mem[stk_ra];
		end
	end

	// Per-class head and tail memories.
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		if (head_re) begin
			head_rd <= head_mem[head_ra];
		end
		if (tail_we) begin
			tail_mem[tail_wa] <= tail_wd;
		end
		if (tail_re) begin
			tail_rd <= tail_mem[tail_ra];
		end
	end

	// Command and slot holding registers.
	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		slot_q <= slot_d;
		last_q <= last_d;
		if (emit) begin
			out_tag_q  <= emit_tag;
			out_cls_q  <= emit_cls;
			out_stat_q <= emit_stat;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrci_pkg::S_IDLE;
			mask_q      <= '0;
			rr_q        <= '0;
			free_q      <= NW'(rrci_pkg::MAX_ITEMS);
			stk_cnt_q   <= '0;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			mask_q    <= mask_d;
			rr_q      <= rr_d;
			free_q    <= free_d;
			stk_cnt_q <= stk_cnt_d;
			fresh_q   <= fresh_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
